[src/assert_macros.svh]
// Assertion helpers for the checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A clocked property that is switched off while reset is high.
`define LEB_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Same-cycle implication built on the macro above.
`define LEB_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  `LEB_ASSERT(label, clk, rst, (ante) |-> (cons), msg)

`endif

[src/leb_pkg.sv]
package leb_pkg;

  localparam int LINE_CAPACITY = 2048;
  localparam int ADDR_W        = $clog2(LINE_CAPACITY);
  localparam int LEN_W         = $clog2(LINE_CAPACITY + 1);

  localparam int KIND_W  = 4;
  localparam int CHAR_W  = 8;
  localparam int RIDX_W  = 11;
  localparam int FIELD_W = 12;
  localparam int CMP_W   = (LEN_W > RIDX_W) ? LEN_W : RIDX_W;

  localparam int IN_BITS     = CHAR_W + RIDX_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int RES_W       = 1 + 2 * FIELD_W + CHAR_W;
  localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

  // Bit positions of the result fields inside the output word.
  localparam int OUT_LEN_LSB  = 1;
  localparam int OUT_CUR_LSB  = OUT_LEN_LSB + FIELD_W;
  localparam int OUT_CHAR_LSB = OUT_CUR_LSB + FIELD_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT    = 4'd0,
    KIND_BACKSPACE = 4'd1,
    KIND_DELETE    = 4'd2,
    KIND_LEFT      = 4'd3,
    KIND_RIGHT     = 4'd4,
    KIND_HOME      = 4'd5,
    KIND_END       = 4'd6,
    KIND_ESCAPE    = 4'd7,
    KIND_CLEAR     = 4'd8,
    KIND_READ      = 4'd9
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_PUT,
    ST_RDWAIT,
    ST_DONE
  } state_t;

  // Result word, accepted flag in the lowest bit.
  typedef struct packed {
    logic [CHAR_W-1:0]  read_char;
    logic [FIELD_W-1:0] out_cursor;
    logic [FIELD_W-1:0] out_length;
    logic               accepted;
  } result_t;

endpackage

[src/line_edit_buffer.sv]
// Line edit buffer: one editable line of bytes with a cursor, kept in a
// single-port-write, single-port-read RAM of LINE_CAPACITY bytes.
// Input channel s_axis: each word is one edit. tuser carries the kind (insert,
// backspace, delete, left, right, home, end, escape, clear, read), tdata carries
// the byte to insert and the index to read. Output channel m_axis returns exactly
// one word per input word: accepted flag, length, cursor and the byte read.
// cfg_we/cfg_wdata write the clear_on_escape bit; write it only while idle.
// One word is worked on at a time. Moves, home, end, escape, clear and refused
// edits need no RAM access and go from the accepted word straight to the result
// step; a read first waits for its RAM read. Insert, backspace and delete first
// shift the tail of the line one entry over, as the tail moves one byte per cycle
// from the RAM read port into the write port, and an insert then writes its byte;
// the worst case is an insert at the head of a line of 2047 bytes. The input
// opens again in the cycle after the result is loaded.
// A stalled receiver holds the finished result in place; the next word is still
// taken, and its result waits in its final step until the output register is free.
// Reset (rst, synchronous) empties the line, homes the cursor, clears the
// clear_on_escape bit and drops any pending result. The RAM is not cleared;
// only bytes below the current length are ever read back.
module line_edit_buffer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [7:0] char_in, [18:8] read_index, upper bits zero
  input  logic [leb_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // [3:0] kind
  input  logic [leb_pkg::KIND_W-1:0]     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [0] accepted, [12:1] out_length, [24:13] out_cursor, [32:25] read_char,
  // upper bits zero
  output logic [leb_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                           cfg_we,
  input  logic                           cfg_wdata
);
  import leb_pkg::*;

  // Control state.
  state_t           state, state_next;
  logic             clear_on_escape;
  logic [LEN_W-1:0] line_length;
  logic [LEN_W-1:0] cursor;
  logic             rd_valid;    // a shift read was issued last cycle
  logic             out_valid;

  // Work registers for the item in flight.
  logic [LEN_W-1:0]  shift_count;
  logic [LEN_W-1:0]  shift_ptr;
  logic              shift_down;  // removal: bytes move toward lower addresses
  logic              is_insert;
  logic [CHAR_W-1:0] char_q;
  logic [ADDR_W-1:0] put_addr;
  logic [ADDR_W-1:0] wr_addr_q;
  logic              res_ok;
  logic [CHAR_W-1:0] res_char;
  result_t           out_q;

  // Line storage.
  logic [CHAR_W-1:0] line_store [LINE_CAPACITY];
  logic [CHAR_W-1:0] rd_data;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CHAR_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;

  // Input fields.
  logic [KIND_W-1:0] in_kind;
  logic [CHAR_W-1:0] in_char;
  logic [RIDX_W-1:0] in_ridx;

  // Decoded plan for an accepted word.
  logic             d_ok;
  logic [LEN_W-1:0] d_len;
  logic [LEN_W-1:0] d_cur;
  logic [LEN_W-1:0] d_cnt;
  logic [LEN_W-1:0] d_ptr;
  logic             d_down;
  logic             d_ins;
  logic             d_rd;

  logic accept;
  logic issue;
  logic out_load;

  assign in_kind = s_axis_tuser;
  assign in_char = s_axis_tdata[CHAR_W-1:0];
  assign in_ridx = s_axis_tdata[CHAR_W +: RIDX_W];

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign issue         = (state == ST_SHIFT) && (shift_count != '0);
  assign out_load      = (state == ST_DONE) && (!out_valid || m_axis_tready);

  // Work out the new length and cursor at once; the RAM tail move is then a
  // plain count of reads from a start address, each written back one entry over.
  always_comb begin
    d_ok   = 1'b0;
    d_len  = line_length;
    d_cur  = cursor;
    d_cnt  = '0;
    d_ptr  = line_length - LEN_W'(1);
    d_down = 1'b0;
    d_ins  = 1'b0;
    d_rd   = 1'b0;
    unique case (in_kind)
      KIND_INSERT: begin
        if (line_length < LEN_W'(LINE_CAPACITY)) begin
          d_ok  = 1'b1;
          d_len = line_length + LEN_W'(1);
          d_cur = cursor + LEN_W'(1);
          d_cnt = line_length - cursor;
          d_ins = 1'b1;
        end
      end
      KIND_BACKSPACE: begin
        if (cursor != '0) begin
          d_ok   = 1'b1;
          d_len  = line_length - LEN_W'(1);
          d_cur  = cursor - LEN_W'(1);
          d_cnt  = line_length - cursor;
          d_ptr  = cursor;
          d_down = 1'b1;
        end
      end
      KIND_DELETE: begin
        if (cursor < line_length) begin
          d_ok   = 1'b1;
          d_len  = line_length - LEN_W'(1);
          d_cnt  = line_length - cursor - LEN_W'(1);
          d_ptr  = cursor + LEN_W'(1);
          d_down = 1'b1;
        end
      end
      KIND_LEFT: begin
        if (cursor != '0) begin
          d_ok  = 1'b1;
          d_cur = cursor - LEN_W'(1);
        end
      end
      KIND_RIGHT: begin
        if (cursor < line_length) begin
          d_ok  = 1'b1;
          d_cur = cursor + LEN_W'(1);
        end
      end
      KIND_HOME: begin
        d_ok  = 1'b1;
        d_cur = '0;
      end
      KIND_END: begin
        d_ok  = 1'b1;
        d_cur = line_length;
      end
      KIND_ESCAPE: begin
        if (clear_on_escape) begin
          d_ok  = 1'b1;
          d_len = '0;
          d_cur = '0;
        end
      end
      KIND_CLEAR: begin
        d_ok  = 1'b1;
        d_len = '0;
        d_cur = '0;
      end
      KIND_READ: begin
        d_rd = 1'b1;
        d_ok = CMP_W'(in_ridx) < CMP_W'(line_length);
      end
      default: begin
        d_ok = 1'b0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (d_rd) begin
            state_next = ST_RDWAIT;
          end else if (d_ins || d_down) begin
            state_next = ST_SHIFT;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SHIFT: begin
        if (shift_count == '0) begin
          state_next = is_insert ? ST_PUT : ST_DONE;
        end
      end
      ST_PUT:    state_next = ST_DONE;
      ST_RDWAIT: state_next = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // RAM port control. A shift write lands in the cycle after its read; the
  // inserted byte goes in only after the last shift write, so the two
  // write sources never meet. Reads and writes of a shift are always two
  // entries apart, so no forwarding is needed.
  always_comb begin
    mem_raddr = (state == ST_IDLE) ? ADDR_W'(in_ridx) : shift_ptr[ADDR_W-1:0];
    mem_we    = rd_valid || (state == ST_PUT);
    mem_waddr = rd_valid ? wr_addr_q : put_addr;
    mem_wdata = rd_valid ? rd_data : char_q;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_store[mem_waddr] <= mem_wdata;
    end
    rd_data <= line_store[mem_raddr];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      clear_on_escape <= 1'b0;
      line_length     <= '0;
      cursor          <= '0;
      rd_valid        <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= issue;
      if (cfg_we) begin
        clear_on_escape <= cfg_wdata;
      end
      if (accept) begin
        line_length <= d_len;
        cursor      <= d_cur;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Work and result registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      shift_count <= d_cnt;
      shift_ptr   <= d_ptr;
      shift_down  <= d_down;
      is_insert   <= d_ins;
      char_q      <= in_char;
      put_addr    <= cursor[ADDR_W-1:0];
      res_ok      <= d_ok;
      res_char    <= '0;
    end
    if (issue) begin
      shift_count <= shift_count - LEN_W'(1);
      if (shift_down) begin
        shift_ptr <= shift_ptr + LEN_W'(1);
        wr_addr_q <= ADDR_W'(shift_ptr - LEN_W'(1));
      end else begin
        shift_ptr <= shift_ptr - LEN_W'(1);
        wr_addr_q <= ADDR_W'(shift_ptr + LEN_W'(1));
      end
    end
    if (state == ST_RDWAIT) begin
      res_char <= res_ok ? rd_data : '0;
    end
    if (out_load) begin
      out_q.accepted   <= res_ok;
      out_q.out_length <= FIELD_W'(line_length);
      out_q.out_cursor <= FIELD_W'(cursor);
      out_q.read_char  <= res_char;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_TDATA_W'(out_q);

endmodule

[src/leb_checker.sv]
`include "assert_macros.svh"

module leb_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [leb_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import leb_pkg::*;

  logic              res_ok;
  logic [FIELD_W-1:0] res_len;
  logic [FIELD_W-1:0] res_cur;
  logic [CHAR_W-1:0]  res_char;

  assign res_ok   = m_axis_tdata[0];
  assign res_len  = m_axis_tdata[OUT_LEN_LSB +: FIELD_W];
  assign res_cur  = m_axis_tdata[OUT_CUR_LSB +: FIELD_W];
  assign res_char = m_axis_tdata[OUT_CHAR_LSB +: CHAR_W];

  // A stalled result must stay put.
  `LEB_ASSERT(a_out_hold, clk, rst,
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata),
    "result changed while stalled")

  // Only one word is in flight, so the input closes right after a word is taken.
  `LEB_ASSERT(a_one_in_flight, clk, rst,
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready,
    "input stayed open after a word was taken")

  // The cursor never passes the end of the line.
  `LEB_ASSERT_IMPLY(a_cursor_in_line, clk, rst,
    m_axis_tvalid, res_cur <= res_len,
    "cursor beyond line length")

  // A refused word never carries a byte.
  `LEB_ASSERT_IMPLY(a_refused_no_char, clk, rst,
    m_axis_tvalid && !res_ok, res_char == '0,
    "refused word carries a byte")

endmodule

bind line_edit_buffer leb_checker u_leb_checker (.*);
